// ===== rtl/pms_pkg.sv =====
`default_nettype none

package pms_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // power-of-two gain scales, as shift counts
   localparam int unsigned PROP_SHIFT = 7;
   localparam int unsigned DERIV_SHIFT = 7;
   localparam int unsigned INTEG_SHIFT = 10;

   localparam int DRIVE_MAX = 255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROP_GAIN       = 3'd0,
      REG_DERIV_GAIN      = 3'd1,
      REG_INTEG_GAIN      = 3'd2,
      REG_FEEDFORWARD     = 3'd3,
      REG_SUM_LIMIT       = 3'd4,
      REG_SETPOINT_FIRST  = 3'd5,
      REG_SETPOINT_SECOND = 3'd6,
      REG_SETPOINT_THIRD  = 3'd7
   } reg_index_type;

   localparam logic signed [15:0] PROP_GAIN_RST = 16'sd33;
   localparam logic signed [15:0] DERIV_GAIN_RST = -16'sd105;
   localparam logic signed [15:0] INTEG_GAIN_RST = 16'sd12;
   localparam logic signed [8:0] FEEDFORWARD_RST = 9'sd100;
   localparam logic [14:0] SUM_LIMIT_RST = 15'd10000;
   localparam logic [7:0] SETPOINT_FIRST_RST = 8'd120;
   localparam logic [7:0] SETPOINT_SECOND_RST = 8'd140;
   localparam logic [7:0] SETPOINT_THIRD_RST = 8'd160;

   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] deriv_gain;
      logic signed [15:0] integ_gain;
      logic signed [8:0]  feedforward;
      logic [14:0]        sum_limit;
      logic [7:0]         setpoint_first;
      logic [7:0]         setpoint_second;
      logic [7:0]         setpoint_third;
   } cfg_type;

   typedef struct packed {
      logic [7:0] drive;
      logic [7:0] setpoint_now;
      logic       run_end;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pms_csr.sv =====
`default_nettype none

module pms_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [pms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pms_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output pms_pkg::cfg_type                         cfg
);

   pms_pkg::cfg_type cfg_ff;
   pms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (pms_pkg::reg_index_type'(csr_index))
            pms_pkg::REG_PROP_GAIN:       cfg_in.prop_gain = csr_wdata;
            pms_pkg::REG_DERIV_GAIN:      cfg_in.deriv_gain = csr_wdata;
            pms_pkg::REG_INTEG_GAIN:      cfg_in.integ_gain = csr_wdata;
            pms_pkg::REG_FEEDFORWARD:     cfg_in.feedforward = csr_wdata[8:0];
            pms_pkg::REG_SUM_LIMIT:       cfg_in.sum_limit = csr_wdata[14:0];
            pms_pkg::REG_SETPOINT_FIRST:  cfg_in.setpoint_first = csr_wdata[7:0];
            pms_pkg::REG_SETPOINT_SECOND: cfg_in.setpoint_second = csr_wdata[7:0];
            pms_pkg::REG_SETPOINT_THIRD:  cfg_in.setpoint_third = csr_wdata[7:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain       <= pms_pkg::PROP_GAIN_RST;
         cfg_ff.deriv_gain      <= pms_pkg::DERIV_GAIN_RST;
         cfg_ff.integ_gain      <= pms_pkg::INTEG_GAIN_RST;
         cfg_ff.feedforward     <= pms_pkg::FEEDFORWARD_RST;
         cfg_ff.sum_limit       <= pms_pkg::SUM_LIMIT_RST;
         cfg_ff.setpoint_first  <= pms_pkg::SETPOINT_FIRST_RST;
         cfg_ff.setpoint_second <= pms_pkg::SETPOINT_SECOND_RST;
         cfg_ff.setpoint_third  <= pms_pkg::SETPOINT_THIRD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/pms_core.sv =====
`default_nettype none

module pms_core #(
   parameter int RUN_LENGTH = 300
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    measured,
   input  wire pms_pkg::cfg_type cfg,
   output pms_pkg::result_type result
);

   localparam int CNT_W = (RUN_LENGTH > 2) ? $clog2(RUN_LENGTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_LENGTH - 1);

   localparam logic [1:0] SP_FIRST  = 2'd0;
   localparam logic [1:0] SP_SECOND = 2'd1;
   localparam logic [1:0] SP_THIRD  = 2'd2;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [7:0]         last_ff, last_in;
   logic signed [15:0] sum_ff, sum_in;
   logic [1:0]         sp_idx_ff, sp_idx_in;

   logic [7:0]         sp;
   logic [1:0]         sp_idx_next;
   logic               first;
   logic               run_end;
   logic signed [8:0]  meas_s;
   logic signed [8:0]  err;
   logic signed [8:0]  delta;
   logic signed [17:0] sum_raw;
   logic signed [17:0] lim_s;
   logic signed [15:0] sum_clamp;
   logic signed [24:0] prod_p, prod_d, bias_p, bias_d;
   logic signed [31:0] prod_i, bias_i;
   logic signed [24:0] adj_p, adj_d;
   logic signed [31:0] adj_i;
   logic signed [16:0] pterm, dterm;
   logic signed [21:0] iterm;
   logic signed [23:0] total;
   logic [7:0]         drive;

   always_comb begin
      case (sp_idx_ff)
         SP_SECOND: begin
            sp = cfg.setpoint_second;
            sp_idx_next = SP_THIRD;
         end
         SP_THIRD: begin
            sp = cfg.setpoint_third;
            sp_idx_next = SP_FIRST;
         end
         default: begin
            sp = cfg.setpoint_first;
            sp_idx_next = SP_SECOND;
         end
      endcase
   end

   assign first   = (count_ff == '0);
   assign run_end = (count_ff == CNT_LAST);
   assign meas_s  = $signed({1'b0, measured});
   assign err     = $signed({1'b0, sp}) - meas_s;
   assign delta   = first ? 9'sd0 : meas_s - $signed({1'b0, last_ff});

   // error sum with symmetric clamp
   assign sum_raw = 18'(sum_ff) + 18'(err);
   assign lim_s   = $signed({3'b000, cfg.sum_limit});

   always_comb begin
      if (sum_raw > lim_s) begin
         sum_clamp = 16'(lim_s);
      end else if (sum_raw < -lim_s) begin
         sum_clamp = 16'(-lim_s);
      end else begin
         sum_clamp = 16'(sum_raw);
      end
   end

   // gain products, shifts truncate toward zero
   assign prod_p = $signed(cfg.prop_gain) * err;
   assign prod_d = $signed(cfg.deriv_gain) * delta;
   assign prod_i = $signed(cfg.integ_gain) * sum_clamp;

   assign bias_p = prod_p[24] ? $signed(25'((1 << pms_pkg::PROP_SHIFT) - 1)) : 25'sd0;
   assign bias_d = prod_d[24] ? $signed(25'((1 << pms_pkg::DERIV_SHIFT) - 1)) : 25'sd0;
   assign bias_i = prod_i[31] ? $signed(32'((1 << pms_pkg::INTEG_SHIFT) - 1)) : 32'sd0;

   assign adj_p = prod_p + bias_p;
   assign adj_d = prod_d + bias_d;
   assign adj_i = prod_i + bias_i;

   assign pterm = 17'(adj_p >>> pms_pkg::PROP_SHIFT);
   assign dterm = 17'(adj_d >>> pms_pkg::DERIV_SHIFT);
   assign iterm = 22'(adj_i >>> pms_pkg::INTEG_SHIFT);

   assign total = 24'(cfg.feedforward) + 24'(pterm) + 24'(dterm) + 24'(iterm);

   always_comb begin
      if (run_end || total < 24'sd0) begin
         drive = 8'd0;
      end else if (total > 24'(pms_pkg::DRIVE_MAX)) begin
         drive = 8'(pms_pkg::DRIVE_MAX);
      end else begin
         drive = total[7:0];
      end
   end

   always_comb begin
      count_in  = count_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      sp_idx_in = sp_idx_ff;
      if (step) begin
         if (run_end) begin
            count_in  = '0;
            last_in   = '0;
            sum_in    = '0;
            sp_idx_in = sp_idx_next;
         end else begin
            count_in  = count_ff + 1'b1;
            last_in   = measured;
            sum_in    = sum_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         last_ff   <= '0;
         sum_ff    <= '0;
         sp_idx_ff <= SP_FIRST;
      end else begin
         count_ff  <= count_in;
         last_ff   <= last_in;
         sum_ff    <= sum_in;
         sp_idx_ff <= sp_idx_in;
      end
   end

   assign result.drive        = drive;
   assign result.setpoint_now = sp;
   assign result.run_end      = run_end;

endmodule

`default_nettype wire

// ===== rtl/pid_motor_speed_step.sv =====
// channel   dir  handshake            word
// req       in   req_valid/req_ready  req_measured
// rsp       out  rsp_valid/rsp_ready  rsp_drive, rsp_setpoint_now, rsp_run_end
// csr       in   csr_wr_en            csr_index, csr_wdata
//
// one word per cycle sustained while rsp_ready holds; a word accepted into the input
// register reaches the result register through the single update pass, once the
// result register is free or draining. reset clears the controller state and loads
// the register defaults. a stalled result holds; the input register keeps taking a
// word while the result register drains in the same cycle.
`default_nettype none

module pid_motor_speed_step #(
   parameter int RUN_LENGTH = 300
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_measured,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_drive,
   output logic [7:0]                            rsp_setpoint_now,
   output logic                                  rsp_run_end,
   input  wire logic                             csr_wr_en,
   input  wire logic [pms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pms_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pms_pkg::cfg_type    cfg;
   pms_pkg::result_type result;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_meas_ff, in_meas_in;
   logic               out_valid_ff, out_valid_in;
   pms_pkg::result_type out_ff, out_in;
   logic               advance;
   logic               take;

   pms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pms_core #(
      .RUN_LENGTH (RUN_LENGTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .measured (in_meas_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_meas_in   = in_meas_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_meas_in  = req_measured;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_meas_ff <= in_meas_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_drive        = out_ff.drive;
   assign rsp_setpoint_now = out_ff.setpoint_now;
   assign rsp_run_end      = out_ff.run_end;

endmodule

`default_nettype wire

// ===== rtl/pms_check.sv =====
`default_nettype none

module pms_check (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [7:0]                       rsp_drive,
   input wire logic [7:0]                       rsp_setpoint_now,
   input wire logic                             rsp_run_end
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_setpoint_now) && $stable(rsp_run_end))
      else $error("result word changed while stalled");

   // no result word straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // run end forces zero drive
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> rsp_drive == 8'd0)
      else $error("nonzero drive on run end");

   // an empty result register never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind pid_motor_speed_step pms_check u_pms_check (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_drive        (rsp_drive),
   .rsp_setpoint_now (rsp_setpoint_now),
   .rsp_run_end      (rsp_run_end)
);

`default_nettype wire

// ===== sim/tb_pid_motor_speed_step.sv =====
`timescale 1ns / 1ps

module tb_pid_motor_speed_step;

   localparam int RUN_LEN = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint PROP_DIV = longint'(1) << pms_pkg::PROP_SHIFT;
   localparam longint DERIV_DIV = longint'(1) << pms_pkg::DERIV_SHIFT;
   localparam longint INTEG_DIV = longint'(1) << pms_pkg::INTEG_SHIFT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_measured = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_drive;
   logic [7:0] rsp_setpoint_now;
   logic rsp_run_end;
   logic csr_wr_en = 1'b0;
   logic [pms_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pms_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pid_motor_speed_step #(
      .RUN_LENGTH(RUN_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_measured(req_measured),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive),
      .rsp_setpoint_now(rsp_setpoint_now),
      .rsp_run_end(rsp_run_end),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // controller copy
   pms_pkg::cfg_type ctrl_cfg;
   logic [15:0] run_count = '0;
   logic [7:0] prev_meas = '0;
   logic signed [16:0] err_acc = '0;
   logic [1:0] sp_sel = '0;

   logic [7:0] samples_to_send[$];
   pms_pkg::result_type predicted_outputs[$];

   int mismatches = 0;
   int words_sent = 0;
   int words_checked = 0;
   int run_ends_seen = 0;
   int settings_loaded = 0;
   int track_level = 128;

   function automatic void predict_control(input logic [7:0] meas);
      pms_pkg::result_type r;
      logic [7:0] sp;
      int unsigned count;
      longint delta, err, sum, lim, pterm, dterm, iterm, total;
      count = run_count + 1;
      case (sp_sel)
         2'd1: sp = ctrl_cfg.setpoint_second;
         2'd2: sp = ctrl_cfg.setpoint_third;
         default: sp = ctrl_cfg.setpoint_first;
      endcase
      delta = (count == 1) ? 0 : longint'(meas) - longint'(prev_meas);
      err = longint'(sp) - longint'(meas);
      dterm = (longint'($signed(ctrl_cfg.deriv_gain)) * delta) / DERIV_DIV;
      pterm = (longint'($signed(ctrl_cfg.prop_gain)) * err) / PROP_DIV;
      lim = longint'(ctrl_cfg.sum_limit);
      sum = longint'(err_acc) + err;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      iterm = (longint'($signed(ctrl_cfg.integ_gain)) * sum) / INTEG_DIV;
      total = longint'($signed(ctrl_cfg.feedforward)) + pterm + dterm + iterm;
      if (total > longint'(pms_pkg::DRIVE_MAX)) total = longint'(pms_pkg::DRIVE_MAX);
      if (total < 0) total = 0;
      r.drive = total[7:0];
      r.setpoint_now = sp;
      r.run_end = (count >= RUN_LEN);
      if (r.run_end) begin
         r.drive = 8'd0;
         err_acc = '0;
         prev_meas = '0;
         run_count = '0;
         sp_sel = (sp_sel == 2'd1) ? 2'd2 : (sp_sel == 2'd2) ? 2'd0 : 2'd1;
      end else begin
         err_acc = sum[16:0];
         prev_meas = meas;
         run_count = count[15:0];
      end
      predicted_outputs.push_back(r);
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_control(req_measured);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (samples_to_send.size() > 0) begin
               next_valid = 1'b1;
               req_measured <= samples_to_send.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // receiver: stall pattern plus two long hold-offs
   int ready_mode = 0;
   int seg_left = 0;
   int hold_left = 0;
   int holds_done = 0;

   always @(posedge clock) begin
      logic next_ready;
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if ((holds_done == 0 && words_sent >= 700) ||
                   (holds_done == 1 && words_sent >= 1500)) begin
         holds_done++;
         hold_left = 300;
         next_ready = 1'b0;
      end else begin
         if (seg_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(1, 40);
         end
         seg_left--;
         case (ready_mode)
            0: next_ready = 1'b1;
            1: next_ready = 1'($urandom_range(0, 1));
            default: next_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
      rsp_ready <= next_ready;
   end

   // result checker
   always @(posedge clock) begin
      pms_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            $error("unexpected word: drive %0d setpoint_now %0d run_end %0d",
                   rsp_drive, rsp_setpoint_now, rsp_run_end);
            mismatches++;
         end else begin
            want = predicted_outputs.pop_front();
            words_checked++;
            if (want.run_end) run_ends_seen++;
            if (rsp_drive !== want.drive) begin
               $error("drive: expected %0d, got %0d", want.drive, rsp_drive);
               mismatches++;
            end
            if (rsp_setpoint_now !== want.setpoint_now) begin
               $error("setpoint_now: expected %0d, got %0d",
                      want.setpoint_now, rsp_setpoint_now);
               mismatches++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_run_end);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(input pms_pkg::reg_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic load_settings(input pms_pkg::cfg_type c);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(pms_pkg::REG_PROP_GAIN, c.prop_gain);
      write_reg(pms_pkg::REG_DERIV_GAIN, c.deriv_gain);
      write_reg(pms_pkg::REG_INTEG_GAIN, c.integ_gain);
      write_reg(pms_pkg::REG_FEEDFORWARD, {junk[15:9], c.feedforward});
      write_reg(pms_pkg::REG_SUM_LIMIT, {junk[0], c.sum_limit});
      write_reg(pms_pkg::REG_SETPOINT_FIRST, {junk[8:1], c.setpoint_first});
      write_reg(pms_pkg::REG_SETPOINT_SECOND, {junk[12:5], c.setpoint_second});
      write_reg(pms_pkg::REG_SETPOINT_THIRD, {junk[15:8], c.setpoint_third});
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ctrl_cfg = c;
      settings_loaded++;
   endtask

   function automatic logic signed [15:0] random_gain();
      int v;
      if ($urandom_range(0, 2) == 0) return 16'($urandom);
      v = $urandom_range(0, 600);
      return 16'(v - 300);
   endfunction

   function automatic pms_pkg::cfg_type random_settings();
      pms_pkg::cfg_type c;
      int v;
      c.prop_gain = random_gain();
      c.deriv_gain = random_gain();
      c.integ_gain = random_gain();
      v = $urandom_range(0, 510);
      c.feedforward = 9'(v - 255);
      c.sum_limit = $urandom_range(0, 1) ? 15'($urandom_range(0, 400)) : 15'($urandom);
      c.setpoint_first = 8'($urandom_range(0, 255));
      c.setpoint_second = 8'($urandom_range(0, 255));
      c.setpoint_third = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // mix of noise, hovering near a setpoint, drifting and converging
   task automatic queue_samples(input int n);
      int mode, left, v, sp;
      left = 0;
      mode = 0;
      sp = 0;
      for (int k = 0; k < n; k++) begin
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(5, 60);
            case ($urandom_range(0, 2))
               0: sp = int'(ctrl_cfg.setpoint_first);
               1: sp = int'(ctrl_cfg.setpoint_second);
               default: sp = int'(ctrl_cfg.setpoint_third);
            endcase
         end
         left--;
         case (mode)
            0: v = $urandom_range(0, 255);
            1: v = sp + int'($urandom_range(0, 16)) - 8;
            2: v = track_level + int'($urandom_range(0, 10)) - 5;
            default: v = (track_level < sp) ? track_level + int'($urandom_range(0, 6))
                                            : track_level - int'($urandom_range(0, 6));
         endcase
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         track_level = v;
         samples_to_send.push_back(8'(v));
      end
   endtask

   task automatic drain();
      while (samples_to_send.size() > 0 || req_valid || predicted_outputs.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** pid_motor_speed_step: FAILED **");
      $finish;
   end

   initial begin
      pms_pkg::cfg_type defaults, c;
      logic [7:0] directed[$];
      defaults.prop_gain = pms_pkg::PROP_GAIN_RST;
      defaults.deriv_gain = pms_pkg::DERIV_GAIN_RST;
      defaults.integ_gain = pms_pkg::INTEG_GAIN_RST;
      defaults.feedforward = pms_pkg::FEEDFORWARD_RST;
      defaults.sum_limit = pms_pkg::SUM_LIMIT_RST;
      defaults.setpoint_first = pms_pkg::SETPOINT_FIRST_RST;
      defaults.setpoint_second = pms_pkg::SETPOINT_SECOND_RST;
      defaults.setpoint_third = pms_pkg::SETPOINT_THIRD_RST;
      ctrl_cfg = defaults;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings; first word of the run has no derivative
      directed = {8'd0, 8'd255, 8'd0, 8'd255, 8'd120, 8'd119, 8'd121, 8'd1, 8'd254,
                  8'd128, 8'd127, 8'd0, 8'd0, 8'd255, 8'd255, 8'd60, 8'd200};
      foreach (directed[k]) samples_to_send.push_back(directed[k]);
      drain();

      c.prop_gain = 16'sh7fff;
      c.deriv_gain = 16'sh8000;
      c.integ_gain = 16'sh7fff;
      c.feedforward = 9'sd255;
      c.sum_limit = 15'h7fff;
      c.setpoint_first = 8'd0;
      c.setpoint_second = 8'd255;
      c.setpoint_third = 8'd128;
      load_settings(c);
      queue_samples(200);
      drain();

      c.prop_gain = 16'sh8000;
      c.deriv_gain = 16'sh7fff;
      c.integ_gain = 16'sh8000;
      c.feedforward = -9'sd255;
      c.sum_limit = 15'd0;
      c.setpoint_first = 8'd255;
      c.setpoint_second = 8'd0;
      c.setpoint_third = 8'd1;
      load_settings(c);
      queue_samples(200);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         load_settings(random_settings());
         queue_samples(200);
         drain();
      end

      load_settings(defaults);
      queue_samples(200);
      drain();

      repeat (10) @(posedge clock);
      if (predicted_outputs.size() != 0) begin
         $error("%0d expected words never arrived", predicted_outputs.size());
         mismatches++;
      end
      $display("covered %0d samples under %0d register settings, incl. extremes",
               words_sent, settings_loaded);
      $display("checked %0d result words, %0d run ends, %0d mismatches",
               words_checked, run_ends_seen, mismatches);
      if (mismatches == 0)
         $display("** pid_motor_speed_step: PASSED **");
      else
         $display("** pid_motor_speed_step: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pms_pkg.sv
rtl/pms_csr.sv
rtl/pms_core.sv
rtl/pid_motor_speed_step.sv
rtl/pms_check.sv
sim/tb_pid_motor_speed_step.sv
